@@ rtl/pfa_pkg.sv @@
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, codes and sizes shared by the Pareto archive core and its cells.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int CAPACITY = 32;
	localparam int CountW   = $clog2(CAPACITY + 1);
	localparam int IdxW     = $clog2(CAPACITY);

	localparam logic [2:0] STS_ACCEPTED   = 3'd0;
	localparam logic [2:0] STS_DOMINATED  = 3'd1;
	localparam logic [2:0] STS_DUPLICATE  = 3'd2;
	localparam logic [2:0] STS_FULL       = 3'd3;
	localparam logic [2:0] STS_DUMP_ENTRY = 3'd4;
	localparam logic [2:0] STS_DUMP_EMPTY = 3'd5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	typedef struct packed {
		logic signed [31:0] ret;
		logic [30:0]        risk;
	} pfa_point_t;

	typedef struct packed {
		logic       valid;
		pfa_point_t pt;
	} pfa_slot_t;

	// compare results a cell reports, plus the evict ripple chain and gt flag it passes up
	typedef struct packed {
		logic dom;       // held entry dominates the candidate
		logic dup;       // held entry equals the candidate
		logic evict;     // this cell or one below it is evicting
		logic gt;        // held entry sorts after the candidate, or slot empty
	} pfa_flags_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_EVICT,
		OP_PLACE,
		OP_ROTATE
	} pfa_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EVICT,
		ST_PLACE,
		ST_DUMP
	} pfa_state_t;

endpackage

@@ rtl/pfa_cell.sv @@
// ----------------------------------------------------------------------------
// pfa_cell
// One archive slot: compares its entry with the candidate and moves data
// to or from its neighbors on evict, place and dump rotation.
// ----------------------------------------------------------------------------
module pfa_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pfa_pkg::pfa_op_t   op,
	input  pfa_pkg::pfa_point_t cand,
	input  pfa_pkg::pfa_slot_t below,
	input  pfa_pkg::pfa_slot_t above,
	input  pfa_pkg::pfa_point_t head,
	input  logic               evict_in,
	input  logic               gt_in,
	output pfa_pkg::pfa_slot_t slot,
	output pfa_pkg::pfa_flags_t flags
);

	pfa_pkg::pfa_slot_t slot_q;
	pfa_pkg::pfa_slot_t slot_d;
	logic own_evict;
	logic own_gt;

	always_comb begin
		flags.dom = slot_q.valid && (slot_q.pt.ret >= cand.ret) && (slot_q.pt.risk <= cand.risk)
			&& ((slot_q.pt.ret > cand.ret) || (slot_q.pt.risk < cand.risk));
		flags.dup = slot_q.valid && (slot_q.pt.ret == cand.ret) && (slot_q.pt.risk == cand.risk);
		own_evict = slot_q.valid && (cand.ret >= slot_q.pt.ret) && (cand.risk <= slot_q.pt.risk)
			&& ((cand.ret > slot_q.pt.ret) || (cand.risk < slot_q.pt.risk));
		own_gt = !slot_q.valid || (slot_q.pt.ret > cand.ret)
			|| ((slot_q.pt.ret == cand.ret) && (slot_q.pt.risk > cand.risk));
		flags.evict = evict_in || own_evict;
		flags.gt    = own_gt;

		slot_d = slot_q;
		unique case (op)
			pfa_pkg::OP_HOLD: begin
			end
			pfa_pkg::OP_EVICT: begin
				// close the gap: everything from the lowest evicted slot moves down
				if (evict_in || own_evict) begin
					slot_d = above;
				end
			end
			pfa_pkg::OP_PLACE: begin
				if (gt_in) begin
					slot_d = below;
				end else if (own_gt) begin
					slot_d.valid = 1'b1;
					slot_d.pt    = cand;
				end
			end
			pfa_pkg::OP_ROTATE: begin
				// wrap the head entry into the topmost valid slot
				if (above.valid) begin
					slot_d.pt = above.pt;
				end else begin
					slot_d.pt = head;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot = slot_q;

endmodule

@@ rtl/pareto_front_archive_core.sv @@
// ----------------------------------------------------------------------------
// pareto_front_archive_core
// Bounded archive of non-dominated (return, risk) points held in a chain of
// slot cells, kept sorted by return then risk, with insert and dump commands.
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   command   start / busy       cmd, cand_return, cand_risk
//   result    done (strobe)      status, removed, front_size, entry_return,
//                                entry_risk, last
//
// A rejected insert (dominated or duplicate) returns its result from the
// compare state. A kept insert passes a compare state, an evict state that
// removes one dominated entry per step until it sees none left, and a place
// state. A dropped insert (full, nothing removed) stops at the evict check.
// A dump emits one entry per cycle by rotating the chain, max(front_size, 1)
// results. Reset empties the archive at once. done is never held off.
module pareto_front_archive_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic signed [31:0]         cand_return,
	input  logic [30:0]                cand_risk,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [5:0]                 removed,
	output logic [5:0]                 front_size,
	output logic signed [31:0]         entry_return,
	output logic [30:0]                entry_risk,
	output logic                       last
);

	localparam int Cap = pfa_pkg::CAPACITY;

	pfa_pkg::pfa_state_t  state_q, state_d;
	pfa_pkg::pfa_op_t     op;
	pfa_pkg::pfa_point_t  cand_q;
	logic [pfa_pkg::CountW-1:0] count_q, count_d;
	logic [pfa_pkg::CountW-1:0] removed_q, removed_d;
	logic [pfa_pkg::CountW-1:0] idx_q, idx_d;

	pfa_pkg::pfa_slot_t  slots [Cap];
	pfa_pkg::pfa_flags_t flags [Cap];
	logic [Cap-1:0] dom_vec, dup_vec, valid_vec;
	logic any_dom, any_dup, any_evict;

	logic                       done_q, out_load;
	logic [2:0]                 status_q, status_d;
	logic [pfa_pkg::CountW-1:0] removed_out_q, removed_out_d;
	logic [pfa_pkg::CountW-1:0] size_q, size_d;
	pfa_pkg::pfa_point_t        entry_q, entry_d;
	logic                       last_q, last_d;

	genvar g;
	generate
		for (g = 0; g < Cap; g++) begin : g_cell
			pfa_pkg::pfa_slot_t below_s, above_s;
			logic evict_in, gt_in;
			if (g == 0) begin : g_bot
				assign below_s  = '0;
				assign evict_in = 1'b0;
				assign gt_in    = 1'b0;
			end else begin : g_mid
				assign below_s  = slots[g-1];
				assign evict_in = flags[g-1].evict;
				assign gt_in    = flags[g-1].gt;
			end
			if (g == Cap - 1) begin : g_top
				assign above_s = '0;
			end else begin : g_low
				assign above_s = slots[g+1];
			end
			pfa_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (op),
				.cand     (cand_q),
				.below    (below_s),
				.above    (above_s),
				.head     (slots[0].pt),
				.evict_in (evict_in),
				.gt_in    (gt_in),
				.slot     (slots[g]),
				.flags    (flags[g])
			);
			assign dom_vec[g]   = flags[g].dom;
			assign dup_vec[g]   = flags[g].dup;
			assign valid_vec[g] = slots[g].valid;
		end
	endgenerate

	assign any_dom   = |dom_vec;
	assign any_dup   = |dup_vec;
	assign any_evict = flags[Cap-1].evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pfa_pkg::ST_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			idx_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
			idx_q     <= idx_d;
			done_q    <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cand_q.ret  <= cand_return;
			cand_q.risk <= cand_risk;
		end
		if (out_load) begin
			status_q      <= status_d;
			removed_out_q <= removed_out_d;
			size_q        <= size_d;
			entry_q       <= entry_d;
			last_q        <= last_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		removed_d     = removed_q;
		idx_d         = idx_q;
		op            = pfa_pkg::OP_HOLD;
		out_load      = 1'b0;
		status_d      = pfa_pkg::STS_ACCEPTED;
		removed_out_d = '0;
		size_d        = count_q;
		entry_d       = '0;
		last_d        = 1'b1;

		unique case (state_q)
			pfa_pkg::ST_IDLE: begin
				if (start) begin
					removed_d = '0;
					idx_d     = '0;
					state_d   = (cmd == pfa_pkg::CMD_DUMP) ? pfa_pkg::ST_DUMP : pfa_pkg::ST_CHECK;
				end
			end
			pfa_pkg::ST_CHECK: begin
				priority if (any_dom) begin
					out_load = 1'b1;
					status_d = pfa_pkg::STS_DOMINATED;
					state_d  = pfa_pkg::ST_IDLE;
				end else if (any_dup) begin
					out_load = 1'b1;
					status_d = pfa_pkg::STS_DUPLICATE;
					state_d  = pfa_pkg::ST_IDLE;
				end else begin
					state_d = pfa_pkg::ST_EVICT;
				end
			end
			pfa_pkg::ST_EVICT: begin
				priority if (any_evict) begin
					op        = pfa_pkg::OP_EVICT;
					removed_d = removed_q + 1'b1;
					count_d   = count_q - 1'b1;
				end else if (count_q == pfa_pkg::CountW'(Cap)) begin
					out_load      = 1'b1;
					status_d      = pfa_pkg::STS_FULL;
					removed_out_d = removed_q;
					state_d       = pfa_pkg::ST_IDLE;
				end else begin
					state_d = pfa_pkg::ST_PLACE;
				end
			end
			pfa_pkg::ST_PLACE: begin
				op            = pfa_pkg::OP_PLACE;
				count_d       = count_q + 1'b1;
				out_load      = 1'b1;
				status_d      = pfa_pkg::STS_ACCEPTED;
				removed_out_d = removed_q;
				size_d        = count_q + 1'b1;
				state_d       = pfa_pkg::ST_IDLE;
			end
			pfa_pkg::ST_DUMP: begin
				out_load = 1'b1;
				if (count_q == '0) begin
					status_d = pfa_pkg::STS_DUMP_EMPTY;
					state_d  = pfa_pkg::ST_IDLE;
				end else begin
					// emit the head and rotate the next entry into it
					op       = pfa_pkg::OP_ROTATE;
					status_d = pfa_pkg::STS_DUMP_ENTRY;
					entry_d  = slots[0].pt;
					last_d   = (idx_q == count_q - 1'b1);
					idx_d    = idx_q + 1'b1;
					if (last_d) begin
						state_d = pfa_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = pfa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != pfa_pkg::ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign removed      = 6'(removed_out_q);
	assign front_size   = 6'(size_q);
	assign entry_return = entry_q.ret;
	assign entry_risk   = entry_q.risk;
	assign last         = last_q;

	// occupied slots form a solid run from the bottom of the chain
	logic [Cap-1:0] therm;
	always_comb begin
		for (int i = 0; i < Cap; i++) begin
			therm[i] = (i < int'(count_q));
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pfa_pkg::CountW'(Cap))
		else $error("entry count above capacity");

	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfa_pkg::ST_IDLE) |-> (valid_vec == therm))
		else $error("slot valid bits disagree with entry count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |=> done)
		else $error("gap inside a dump burst");

endmodule
